// ===== rtl/stq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_pkg
// shared types, codes and helpers of the software timer queue unit
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int SLOT_W      = $clog2(TIMER_SLOTS);
  localparam int TIME_BITS   = 48;
  localparam int PERIOD_W    = 32;
  localparam int TAG_W       = 16;
  localparam int MIN_W       = 20;
  localparam logic [MIN_W-1:0] MIN_DELAY_RST = MIN_W'(100);
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_EXPIRE = 2'd2,
    KIND_DONE   = 2'd3
  } kind_e;

  // kind of pass the slot scanner makes
  typedef enum logic [1:0] {
    SCAN_ADD  = 2'd0,
    SCAN_MARK = 2'd1,
    SCAN_PICK = 2'd2,
    SCAN_BEST = 2'd3
  } scan_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_SCAN,
    ST_ADD_OUT,
    ST_CANCEL,
    ST_MARK,
    ST_PICK,
    ST_PICK_CHECK,
    ST_EMIT,
    ST_BEST,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic  in_load;
    logic  scan_clr;
    logic  scan_step;
    scan_e scan_mode;
    logic  do_add;
    logic  do_cancel;
    logic  do_emit;
    logic  do_done;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic found;
    logic out_free;
    op_e  op;
  } status_t;

  // distance to expiry, clamped below at the minimum delay
  function automatic logic [TIME_BITS-1:0] delay_to(input logic [TIME_BITS-1:0] expiry,
                                                    input logic [TIME_BITS-1:0] now,
                                                    input logic [MIN_W-1:0]     min_d);
    logic [TIME_BITS-1:0] d;
    d = (expiry > now) ? (expiry - now) : '0;
    if (d < TIME_BITS'(min_d)) d = TIME_BITS'(min_d);
    return d;
  endfunction

endpackage

// ===== rtl/software_timer_queue_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// software_timer_queue_unit
// ordered table of one-shot and periodic timers with add, cancel and tick
//
//  channel   direction  payload
//  s_axis    in         tuser: operation; tdata: now, expire, period, slot, tag
//  m_axis    out        tuser: kind; tdata: ok, slot, tag, rearm, delay; tlast
//  apb       in/out     register 0: min_arm_delay_us
//
//  add: a scan over every slot, then the reply; cancel: the reply for the named slot
//  tick: a due-mark pass over every slot, then a pick pass and an expiry result per
//  expired timer, a final empty pick pass, then the earliest search pass and done
//  every pass walks the slot table through one shared read port, a slot a cycle
//  a new item is taken once the previous one has its last result registered
//  a stalled m_axis holds the sequencer; reset empties the table at once
// ----------------------------------------------------------------------------
module software_timer_queue_unit import stq_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [1:0] operation
  input  logic [1:0]   s_axis_tuser_i,
  // [47:0] now_time, [95:48] expire_time, [127:96] period_us,
  // [131:128] cancel_slot, [147:132] cancel_tag
  input  logic [151:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [1:0] kind
  output logic [1:0]   m_axis_tuser_o,
  // [0] ok, [4:1] slot, [20:5] tag, [21] rearm, [69:22] arm_delay
  output logic [71:0]  m_axis_tdata_o,
  output logic         m_axis_tlast_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  cmd_t                 cmd;
  status_t              status;
  logic [MIN_W-1:0]     min_val;
  logic                 cfg_we, ok, rearm;
  logic [3:0]           slot;
  logic [TAG_W-1:0]     tag;
  logic [TIME_BITS-1:0] delay;

  // register write and read decode
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? 32'(min_val) : 32'd0;

  stq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  stq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_op_i     (s_axis_tuser_i),
    .in_now_i    (s_axis_tdata_i[47:0]),
    .in_exp_i    (s_axis_tdata_i[95:48]),
    .in_per_i    (s_axis_tdata_i[127:96]),
    .in_cslot_i  (s_axis_tdata_i[131:128]),
    .in_ctag_i   (s_axis_tdata_i[147:132]),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (pwdata[MIN_W-1:0]),
    .cfg_min_o   (min_val),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_kind_o  (m_axis_tuser_o),
    .out_ok_o    (ok),
    .out_slot_o  (slot),
    .out_tag_o   (tag),
    .out_rearm_o (rearm),
    .out_delay_o (delay),
    .out_last_o  (m_axis_tlast_o)
  );

  // result packing
  assign m_axis_tdata_o = {2'b00, delay, rearm, tag, slot, ok};

endmodule

// ===== rtl/stq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_ctrl
// sequencer for add, cancel and tick operations over the slot table
// ----------------------------------------------------------------------------
module stq_ctrl import stq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (status_i.op)
            OP_ADD:    state_d = ST_ADD_SCAN;
            OP_CANCEL: state_d = ST_CANCEL;
            OP_TICK:   state_d = ST_MARK;
            OP_NONE:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_ADD_SCAN:   if (status_i.scan_last) state_d = ST_ADD_OUT;
      ST_ADD_OUT:    if (status_i.out_free) state_d = ST_IDLE;
      ST_CANCEL:     if (status_i.out_free) state_d = ST_IDLE;
      ST_MARK:       if (status_i.scan_last) state_d = ST_PICK;
      ST_PICK:       if (status_i.scan_last) state_d = ST_PICK_CHECK;
      ST_PICK_CHECK: state_d = status_i.found ? ST_EMIT : ST_BEST;
      ST_EMIT:       if (status_i.out_free) state_d = ST_PICK;
      ST_BEST:       if (status_i.scan_last) state_d = ST_DONE;
      ST_DONE:       if (status_i.out_free) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.in_load  = in_valid_i;
        cmd_o.scan_clr = in_valid_i;
      end
      ST_ADD_SCAN: begin
        cmd_o.scan_step = 1'b1;
        cmd_o.scan_mode = SCAN_ADD;
      end
      ST_ADD_OUT: cmd_o.do_add    = status_i.out_free;
      ST_CANCEL:  cmd_o.do_cancel = status_i.out_free;
      ST_MARK: begin
        cmd_o.scan_step = 1'b1;
        cmd_o.scan_mode = SCAN_MARK;
        cmd_o.scan_clr  = status_i.scan_last;
      end
      ST_PICK: begin
        cmd_o.scan_step = 1'b1;
        cmd_o.scan_mode = SCAN_PICK;
      end
      ST_PICK_CHECK: cmd_o.scan_clr = !status_i.found;
      ST_EMIT: begin
        cmd_o.do_emit  = status_i.out_free;
        cmd_o.scan_clr = status_i.out_free;
      end
      ST_BEST: begin
        cmd_o.scan_step = 1'b1;
        cmd_o.scan_mode = SCAN_BEST;
      end
      ST_DONE: cmd_o.do_done = status_i.out_free;
      default: ;
    endcase
  end

endmodule

// ===== rtl/stq_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_dp
// slot table, slot scanner, config register and result register
// ----------------------------------------------------------------------------
module stq_dp import stq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output status_t              status_o,
  input  logic [1:0]           in_op_i,
  input  logic [TIME_BITS-1:0] in_now_i,
  input  logic [TIME_BITS-1:0] in_exp_i,
  input  logic [PERIOD_W-1:0]  in_per_i,
  input  logic [3:0]           in_cslot_i,
  input  logic [TAG_W-1:0]     in_ctag_i,
  input  logic                 cfg_we_i,
  input  logic [MIN_W-1:0]     cfg_wdata_i,
  output logic [MIN_W-1:0]     cfg_min_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           out_kind_o,
  output logic                 out_ok_o,
  output logic [3:0]           out_slot_o,
  output logic [TAG_W-1:0]     out_tag_o,
  output logic                 out_rearm_o,
  output logic [TIME_BITS-1:0] out_delay_o,
  output logic                 out_last_o
);

  // captured input item
  logic [TIME_BITS-1:0] now_q, exp_q;
  logic [PERIOD_W-1:0]  per_q;
  logic [3:0]           cs_q;
  logic [TAG_W-1:0]     ct_q;

  // slot table
  logic [TIMER_SLOTS-1:0] valid_q, due_q;
  logic [TIME_BITS-1:0]   expiry_q [TIMER_SLOTS];
  logic [PERIOD_W-1:0]    period_q [TIMER_SLOTS];
  logic [TAG_W-1:0]       tag_q    [TIMER_SLOTS];
  logic [TAG_W-1:0]       next_tag_q;
  logic [MIN_W-1:0]       min_q;

  // scanner state
  logic [SLOT_W-1:0]    idx_q, best_idx_q, free_idx_q;
  logic [TIME_BITS-1:0] best_exp_q;
  logic                 found_q, free_found_q, earliest_q;

  // result register
  logic                 ov_q, ok_q, rearm_q, last_q;
  logic [1:0]           kind_q;
  logic [3:0]           slot_q;
  logic [TAG_W-1:0]     otag_q;
  logic [TIME_BITS-1:0] delay_q;

  logic                 out_free;
  logic [SLOT_W-1:0]    rd_addr;
  logic [TIME_BITS-1:0] rd_exp;
  logic [PERIOD_W-1:0]  rd_per;
  logic [TAG_W-1:0]     rd_tag;
  logic                 rd_valid, cancel_hit, take;
  logic [TIME_BITS:0]   restart_sum;
  logic [TIME_BITS-1:0] restart_exp;

  assign out_free = !ov_q || out_ready_i;

  // one read port into the table
  always_comb begin
    priority if (cmd_i.do_cancel) rd_addr = SLOT_W'(cs_q);
    else if (cmd_i.do_emit)       rd_addr = best_idx_q;
    else                          rd_addr = idx_q;
  end
  assign rd_exp   = expiry_q[rd_addr];
  assign rd_per   = period_q[rd_addr];
  assign rd_tag   = tag_q[rd_addr];
  assign rd_valid = valid_q[rd_addr];

  assign cancel_hit  = rd_valid && (rd_tag == ct_q);
  assign restart_sum = {1'b0, now_q} + (TIME_BITS + 1)'(rd_per);
  assign restart_exp = restart_sum[TIME_BITS] ? TIME_MAX : restart_sum[TIME_BITS-1:0];

  // candidate for the earliest due or valid entry
  assign take = ((cmd_i.scan_mode == SCAN_PICK) ? due_q[idx_q] : rd_valid) &&
                (!found_q || rd_exp < best_exp_q);

  assign status_o.scan_last = (idx_q == SLOT_W'(TIMER_SLOTS - 1));
  assign status_o.found     = found_q;
  assign status_o.out_free  = out_free;
  assign status_o.op        = op_e'(in_op_i);

  // input capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      now_q <= in_now_i;
      exp_q <= in_exp_i;
      per_q <= in_per_i;
      cs_q  <= in_cslot_i;
      ct_q  <= in_ctag_i;
    end
  end

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)       min_q <= MIN_DELAY_RST;
    else if (cfg_we_i) min_q <= cfg_wdata_i;
  end
  assign cfg_min_o = min_q;

  // table payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_add && free_found_q) begin
      expiry_q[free_idx_q] <= exp_q;
      period_q[free_idx_q] <= per_q;
      tag_q[free_idx_q]    <= next_tag_q;
    end else if (cmd_i.do_emit && rd_per != '0) begin
      expiry_q[best_idx_q] <= restart_exp;
    end
  end

  // valid and due flags, tag counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      due_q      <= '0;
      next_tag_q <= '0;
    end else begin
      if (cmd_i.do_add && free_found_q) begin
        valid_q[free_idx_q] <= 1'b1;
        next_tag_q          <= next_tag_q + TAG_W'(1);
      end
      if (cmd_i.do_cancel && cancel_hit) valid_q[rd_addr] <= 1'b0;
      if (cmd_i.scan_step && cmd_i.scan_mode == SCAN_MARK)
        due_q[idx_q] <= rd_valid && (rd_exp <= now_q);
      if (cmd_i.do_emit) begin
        due_q[best_idx_q] <= 1'b0;
        if (rd_per == '0) valid_q[best_idx_q] <= 1'b0;
      end
    end
  end

  // slot scanner
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      earliest_q   <= 1'b1;
      best_idx_q   <= '0;
      free_idx_q   <= '0;
      best_exp_q   <= '0;
    end else if (cmd_i.scan_clr) begin
      idx_q        <= '0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      earliest_q   <= 1'b1;
    end else if (cmd_i.scan_step) begin
      idx_q <= idx_q + SLOT_W'(1);
      unique case (cmd_i.scan_mode)
        SCAN_ADD: begin
          if (rd_valid) begin
            if (!(exp_q < rd_exp)) earliest_q <= 1'b0;
          end else if (!free_found_q) begin
            free_found_q <= 1'b1;
            free_idx_q   <= idx_q;
          end
        end
        SCAN_MARK: ;
        SCAN_PICK, SCAN_BEST: begin
          if (take) begin
            found_q    <= 1'b1;
            best_idx_q <= idx_q;
            best_exp_q <= rd_exp;
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (cmd_i.do_add || cmd_i.do_cancel || cmd_i.do_emit || cmd_i.do_done) ov_q <= 1'b1;
    else if (out_ready_i) ov_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_add) begin
      kind_q  <= KIND_ADD;
      ok_q    <= free_found_q;
      slot_q  <= free_found_q ? 4'(free_idx_q) : 4'd0;
      otag_q  <= free_found_q ? next_tag_q : '0;
      rearm_q <= free_found_q && earliest_q;
      delay_q <= (free_found_q && earliest_q) ? delay_to(exp_q, now_q, min_q) : '0;
      last_q  <= 1'b1;
    end else if (cmd_i.do_cancel) begin
      kind_q  <= KIND_CANCEL;
      ok_q    <= cancel_hit;
      slot_q  <= cs_q;
      otag_q  <= ct_q;
      rearm_q <= 1'b0;
      delay_q <= '0;
      last_q  <= 1'b1;
    end else if (cmd_i.do_emit) begin
      kind_q  <= KIND_EXPIRE;
      ok_q    <= 1'b1;
      slot_q  <= 4'(best_idx_q);
      otag_q  <= rd_tag;
      rearm_q <= 1'b0;
      delay_q <= '0;
      last_q  <= 1'b0;
    end else if (cmd_i.do_done) begin
      kind_q  <= KIND_DONE;
      ok_q    <= 1'b0;
      slot_q  <= '0;
      otag_q  <= '0;
      rearm_q <= found_q;
      delay_q <= found_q ? delay_to(best_exp_q, now_q, min_q) : '0;
      last_q  <= 1'b1;
    end
  end

  assign out_valid_o = ov_q;
  assign out_kind_o  = kind_q;
  assign out_ok_o    = ok_q;
  assign out_slot_o  = slot_q;
  assign out_tag_o   = otag_q;
  assign out_rearm_o = rearm_q;
  assign out_delay_o = delay_q;
  assign out_last_o  = last_q;

  // a due entry is always a live entry
  a_due_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (due_q & ~valid_q) == '0) else $error("due flag on a free slot");

  // the tag counter moves only on a successful add
  a_tag_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.do_add && free_found_q) |=> next_tag_q == $past(next_tag_q) + TAG_W'(1))
    else $error("tag counter did not advance");

  a_tag_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.do_add && free_found_q) |=> $stable(next_tag_q))
    else $error("tag counter moved without an add");

  // results are loaded only into a free result register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.do_add || cmd_i.do_cancel || cmd_i.do_emit || cmd_i.do_done) |-> out_free)
    else $error("result register overwritten");

  // expired-timer results never close the run
  a_expire_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && kind_q == KIND_EXPIRE) |-> !last_q) else $error("expire marked last");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for software_timer_queue_unit
// drives add, cancel, tick and no-op transfers with random gaps, predicts every
// reply, expiry and tick-done result from a local copy of the timer table and
// compares each received transfer field by field in arrival order
// ----------------------------------------------------------------------------
module testbench;
  import stq_pkg::*;

  typedef struct packed {
    kind_e                kind;
    logic                 ok;
    logic [SLOT_W-1:0]    slot;
    logic [TAG_W-1:0]     tag;
    logic                 rearm;
    logic [TIME_BITS-1:0] delay;
    logic                 last;
  } timer_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [1:0] s_axis_tuser_i = '0;
  logic [151:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [1:0] m_axis_tuser_o;
  logic [71:0] m_axis_tdata_o;
  logic m_axis_tlast_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  software_timer_queue_unit uut (.*);

  always #1 clk_i = ~clk_i;

  // local copy of the timer table
  logic                 tbl_valid [TIMER_SLOTS];
  logic [TIME_BITS-1:0] tbl_expiry [TIMER_SLOTS];
  logic [PERIOD_W-1:0]  tbl_period [TIMER_SLOTS];
  logic [TAG_W-1:0]     tbl_tag [TIMER_SLOTS];
  logic [TAG_W-1:0]     tag_counter;
  logic [MIN_W-1:0]     min_delay;

  timer_result_t pending_results[$];
  int mismatches = 0;
  int expiries_seen = 0;
  bit hold_off = 0;
  bit rx_stall_enable = 1;

  function automatic logic [TIME_BITS-1:0] clamp_delay(logic [TIME_BITS-1:0] expiry,
                                                       logic [TIME_BITS-1:0] now);
    logic [TIME_BITS-1:0] d;
    d = (expiry > now) ? expiry - now : '0;
    if (d < TIME_BITS'(min_delay)) d = TIME_BITS'(min_delay);
    return d;
  endfunction

  // work out the results of one accepted item
  task automatic predict_timer_op(op_e op, logic [151:0] d);
    logic [TIME_BITS-1:0] now, exp, best, room;
    logic [PERIOD_W-1:0]  per;
    logic [SLOT_W-1:0]    cs;
    logic [TAG_W-1:0]     ct;
    logic                 due [TIMER_SLOTS];
    logic                 earliest, any;
    int                   free_slot, pick;
    timer_result_t        r;
    now = d[47:0];
    exp = d[95:48];
    per = d[127:96];
    cs = d[131:128];
    ct = d[147:132];
    r = '0;
    r.last = 1'b1;
    case (op)
      OP_ADD: begin
        free_slot = -1;
        earliest = 1;
        for (int i = 0; i < TIMER_SLOTS; i++) begin
          if (tbl_valid[i]) begin
            if (!(exp < tbl_expiry[i])) earliest = 0;
          end else if (free_slot < 0) free_slot = i;
        end
        r.kind = KIND_ADD;
        if (free_slot >= 0) begin
          tbl_valid[free_slot] = 1;
          tbl_expiry[free_slot] = exp;
          tbl_period[free_slot] = per;
          tbl_tag[free_slot] = tag_counter;
          r.ok = 1;
          r.slot = SLOT_W'(free_slot);
          r.tag = tag_counter;
          r.rearm = earliest;
          r.delay = earliest ? clamp_delay(exp, now) : '0;
          tag_counter++;
        end
        pending_results.push_back(r);
      end
      OP_CANCEL: begin
        r.kind = KIND_CANCEL;
        r.slot = cs;
        r.tag = ct;
        if (tbl_valid[cs] && tbl_tag[cs] == ct) begin
          tbl_valid[cs] = 0;
          r.ok = 1;
        end
        pending_results.push_back(r);
      end
      OP_TICK: begin
        for (int i = 0; i < TIMER_SLOTS; i++) due[i] = tbl_valid[i] && tbl_expiry[i] <= now;
        forever begin
          pick = -1;
          for (int i = 0; i < TIMER_SLOTS; i++)
            if (due[i] && (pick < 0 || tbl_expiry[i] < tbl_expiry[pick])) pick = i;
          if (pick < 0) break;
          due[pick] = 0;
          r = '0;
          r.kind = KIND_EXPIRE;
          r.ok = 1;
          r.slot = SLOT_W'(pick);
          r.tag = tbl_tag[pick];
          pending_results.push_back(r);
          if (tbl_period[pick] != 0) begin
            room = TIME_MAX - now;
            tbl_expiry[pick] = (TIME_BITS'(tbl_period[pick]) > room) ? TIME_MAX
                               : now + TIME_BITS'(tbl_period[pick]);
          end else tbl_valid[pick] = 0;
        end
        any = 0;
        best = '0;
        for (int i = 0; i < TIMER_SLOTS; i++)
          if (tbl_valid[i] && (!any || tbl_expiry[i] < best)) begin
            best = tbl_expiry[i];
            any = 1;
          end
        r = '0;
        r.kind = KIND_DONE;
        r.rearm = any;
        r.delay = any ? clamp_delay(best, now) : '0;
        r.last = 1;
        pending_results.push_back(r);
      end
      default: ;
    endcase
  endtask

  // send one item and wait for its transfer
  task automatic send_item(op_e op, logic [TIME_BITS-1:0] now, logic [TIME_BITS-1:0] exp,
                           logic [PERIOD_W-1:0] per, logic [SLOT_W-1:0] cs,
                           logic [TAG_W-1:0] ct, bit no_gap = 0);
    logic [151:0] d;
    int gap;
    d = {4'b0, ct, cs, per, exp, now};
    gap = no_gap ? 0 : (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 2));
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(posedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= op;
    s_axis_tdata_i <= d;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_timer_op(op, d);
    s_axis_tvalid_i <= 1'b0;
    s_axis_tuser_i <= 2'($urandom);
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_min_delay(logic [MIN_W-1:0] v);
    psel <= 1; pwrite <= 1; paddr <= '0; pwdata <= 32'(v); penable <= 0;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    min_delay = v;
  endtask

  // result checker
  always @(posedge clk_i) begin
    timer_result_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.kind = kind_e'(m_axis_tuser_o);
      got.ok = m_axis_tdata_o[0];
      got.slot = m_axis_tdata_o[4:1];
      got.tag = m_axis_tdata_o[20:5];
      got.rearm = m_axis_tdata_o[21];
      got.delay = m_axis_tdata_o[69:22];
      got.last = m_axis_tlast_o;
      if (got.kind == KIND_EXPIRE) expiries_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("expected %p actual %p", want, got);
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (hold_off) m_axis_tready_i <= 1'b0;
    else if (!rx_stall_enable) m_axis_tready_i <= 1'b1;
    else m_axis_tready_i <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 4) != 0);
  end

  task automatic test_add_cancel_edges();
    send_item(OP_ADD, 0, TIME_MAX, 32'hFFFF_FFFF, 0, 0);
    send_item(OP_ADD, TIME_MAX, 0, 0, 0, 0);
    send_item(OP_ADD, 10, 50, 0, 0, 0);
    send_item(OP_ADD, 10, 50, 5, 0, 0);
    send_item(OP_CANCEL, 0, 0, 0, 4'hF, 16'hFFFF);
    send_item(OP_CANCEL, 0, 0, 0, 1, 16'h0);
    send_item(OP_CANCEL, 0, 0, 0, 1, 16'h1);
    send_item(OP_NONE, 0, 0, 0, 0, 0);
    send_item(OP_TICK, 60, 0, 0, 0, 0);
    send_item(OP_TICK, TIME_MAX - 3, 0, 0, 0, 0);
    send_item(OP_TICK, TIME_MAX, 0, 0, 0, 0);
    wait_drained();
  endtask

  task automatic test_table_full();
    for (int i = 0; i < TIMER_SLOTS + 2; i++)
      send_item(OP_ADD, 0, TIME_BITS'(1000 + $urandom_range(0, 3)),
                (i % 2) ? 32'd0 : 32'd7, 0, 0);
    send_item(OP_TICK, 2000, 0, 0, 0, 0);
    send_item(OP_TICK, TIME_MAX, 0, 0, 0, 0);
    wait_drained();
  endtask

  // long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk_i);
        hold_off = 0;
      end
      for (int i = 0; i < 8; i++)
        send_item(OP_ADD, 0, TIME_BITS'($urandom_range(0, 50)), 0, 0, 0, 1);
    join
    send_item(OP_TICK, 100, 0, 0, 0, 0, 1);
    wait_drained();
  endtask

  task automatic test_random_mix(int count);
    logic [TIME_BITS-1:0] clock_now;
    logic [TIME_BITS-1:0] e;
    logic [SLOT_W-1:0] s;
    int pick;
    clock_now = TIME_BITS'({$urandom, $urandom}) & 48'h00FF_FFFF_FFFF;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (n % 40 == 39) rx_stall_enable = !rx_stall_enable;
      if (pick < 40) begin
        e = clock_now + $urandom_range(0, 3000);
        if ($urandom_range(0, 15) == 0) e = TIME_BITS'({$urandom, $urandom});
        send_item(OP_ADD, clock_now, e, ($urandom_range(0, 1) ? 32'($urandom_range(1, 2000))
                  : ($urandom_range(0, 7) == 0 ? $urandom : 32'd0)), 0, 0);
      end else if (pick < 60) begin
        s = SLOT_W'($urandom);
        send_item(OP_CANCEL, 0, 0, 0, s,
                  ($urandom_range(0, 3) != 0 && tbl_valid[s]) ? tbl_tag[s] : 16'($urandom));
      end else if (pick < 97) begin
        clock_now += $urandom_range(0, 1500);
        send_item(OP_TICK, clock_now, 0, 0, 0, 0);
      end else begin
        send_item(OP_NONE, TIME_BITS'($urandom), TIME_BITS'($urandom), $urandom,
                  SLOT_W'($urandom), TAG_W'($urandom));
      end
    end
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      tbl_valid[i] = 0; tbl_expiry[i] = '0; tbl_period[i] = '0; tbl_tag[i] = '0;
    end
    tag_counter = '0;
    min_delay = MIN_DELAY_RST;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_add_cancel_edges();
    write_min_delay('0);
    test_table_full();
    write_min_delay(20'hFFFFF);
    test_backpressure();
    write_min_delay(20'd700);
    test_random_mix(150);
    write_min_delay(20'd5);
    test_random_mix(150);
    if (mismatches == 0 && pending_results.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end
endmodule
